// File: rtl/core/dsfr_pkg.sv
`default_nettype none

package dsfr_pkg;

    // item codes on the op field
    localparam logic OP_ROUND = 1'b0;
    localparam logic OP_FINAL = 1'b1;

    // control of the item held in the input register
    typedef struct packed {
        logic valid;
        logic op;
    } item_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/dsfr_in_stage.sv
`default_nettype none

module dsfr_in_stage #(
    parameter int CHECK_BITS = 16
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_op,
    input  wire  [CHECK_BITS-1:0]      s_check_bits,
    input  wire  [CHECK_BITS:0]        s_data_bits,
    input  wire                        advance,
    output dsfr_pkg::item_ctrl_t       item_ctrl,
    output logic [CHECK_BITS-1:0]      item_check,
    output logic [CHECK_BITS:0]        item_data
);
    import dsfr_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic                  op_reg;
    logic [CHECK_BITS-1:0] check_reg;
    logic [CHECK_BITS:0]   data_reg;

    // free slot when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture on input transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_op;
            check_reg <= s_check_bits;
            data_reg  <= s_data_bits;
        end
    end

    assign item_ctrl.valid = valid_reg;
    assign item_ctrl.op    = op_reg;
    assign item_check      = check_reg;
    assign item_data       = data_reg;

endmodule

`default_nettype wire

// File: rtl/core/dsfr_syndrome.sv
`default_nettype none

module dsfr_syndrome #(
    parameter int CHECK_BITS = 16
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        reset_mode,
    input  wire                        advance,
    input  dsfr_pkg::item_ctrl_t       item_ctrl,
    input  wire  [CHECK_BITS-1:0]      item_check,
    input  wire  [CHECK_BITS:0]        item_data,
    output logic [CHECK_BITS-1:0]      det_bits,
    output logic                       det_final
);
    import dsfr_pkg::*;

    logic [CHECK_BITS-1:0] prev_round_reg;
    logic [CHECK_BITS-1:0] prev_round_next;
    logic [CHECK_BITS-1:0] prev_diff_reg;
    logic [CHECK_BITS-1:0] prev_diff_next;
    logic [CHECK_BITS-1:0] diff;
    logic [CHECK_BITS-1:0] neigh;

    // round difference and neighbor parity of the data readout
    assign diff  = item_check ^ prev_round_reg;
    assign neigh = item_data[CHECK_BITS-1:0] ^ item_data[CHECK_BITS:1];

    always_comb begin
        prev_round_next = prev_round_reg;
        prev_diff_next  = prev_diff_reg;
        det_bits        = '0;
        det_final       = 1'b0;
        case (item_ctrl.op)
            OP_ROUND: begin
                det_bits        = reset_mode ? diff : (diff ^ prev_diff_reg);
                prev_round_next = item_check;
                prev_diff_next  = diff;
            end
            default: begin
                // final readout closes the shot and clears history
                det_bits        = neigh ^ (reset_mode ? prev_round_reg : prev_diff_reg);
                det_final       = 1'b1;
                prev_round_next = '0;
                prev_diff_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_round_reg <= '0;
            prev_diff_reg  <= '0;
        end else if (advance) begin
            prev_round_reg <= prev_round_next;
            prev_diff_reg  <= prev_diff_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dsfr_out_stage.sv
`default_nettype none

module dsfr_out_stage #(
    parameter int CHECK_BITS = 16
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        load,
    input  wire  [CHECK_BITS-1:0]      det_bits,
    input  wire                        det_final,
    output logic                       can_load,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [CHECK_BITS-1:0]      m_detector_bits,
    output logic                       m_is_final
);
    import dsfr_pkg::*;

    logic                  valid_reg;
    logic [CHECK_BITS-1:0] det_reg;
    logic                  final_reg;

    // result slot frees when empty or when taken this cycle
    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            det_reg   <= det_bits;
            final_reg <= det_final;
        end
    end

    assign m_valid         = valid_reg;
    assign m_detector_bits = det_reg;
    assign m_is_final      = final_reg;

endmodule

`default_nettype wire

// File: rtl/core/detector_syndrome_from_rounds.sv
// channel   | direction | handshake          | payload
// s_        | in        | s_valid / s_ready  | s_op, s_check_bits, s_data_bits
// m_        | out       | m_valid / m_ready  | m_detector_bits, m_is_final
// cfg_      | in        | cfg_we             | cfg_wdata (reset_mode)
//
// one item per cycle sustained while m_ready stays high; the input register, then
// the result register after the xor logic, lie between the input transfer and the
// result transfer
// aresetn is synchronous active low: clears both stages, round history and
// reset_mode; a stall on m_ready holds the result and backs up into s_ready
`default_nettype none

module detector_syndrome_from_rounds #(
    parameter int CHECK_BITS = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_we,
    input  wire                    cfg_wdata,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    s_op,
    input  wire  [CHECK_BITS-1:0]  s_check_bits,
    input  wire  [CHECK_BITS:0]    s_data_bits,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [CHECK_BITS-1:0]  m_detector_bits,
    output logic                   m_is_final
);
    import dsfr_pkg::*;

    logic                  reset_mode_reg;
    item_ctrl_t            item_ctrl;
    logic [CHECK_BITS-1:0] item_check;
    logic [CHECK_BITS:0]   item_data;
    logic [CHECK_BITS-1:0] det_bits;
    logic                  det_final;
    logic                  can_load;
    logic                  advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            reset_mode_reg <= cfg_wdata;
        end
    end

    // held item moves into the result register
    assign advance = item_ctrl.valid && can_load;

    dsfr_in_stage #(
        .CHECK_BITS (CHECK_BITS)
    ) u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_check_bits (s_check_bits),
        .s_data_bits  (s_data_bits),
        .advance      (advance),
        .item_ctrl    (item_ctrl),
        .item_check   (item_check),
        .item_data    (item_data)
    );

    dsfr_syndrome #(
        .CHECK_BITS (CHECK_BITS)
    ) u_syndrome (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .reset_mode (reset_mode_reg),
        .advance    (advance),
        .item_ctrl  (item_ctrl),
        .item_check (item_check),
        .item_data  (item_data),
        .det_bits   (det_bits),
        .det_final  (det_final)
    );

    dsfr_out_stage #(
        .CHECK_BITS (CHECK_BITS)
    ) u_out_stage (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (advance),
        .det_bits        (det_bits),
        .det_final       (det_final),
        .can_load        (can_load),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_detector_bits (m_detector_bits),
        .m_is_final      (m_is_final)
    );

`ifndef SYNTHESIS
    // an empty input register always takes a transfer
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_ctrl.valid |-> s_ready)
        else $error("input register empty but s_ready low");

    // a final item reaching the result register shows up flagged as final
    a_final_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_ctrl.op == OP_FINAL) |=> (m_valid && m_is_final))
        else $error("final readout result missing or not flagged");

    // a round item reaching the result register is never flagged final
    a_round_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_ctrl.op == OP_ROUND) |=> (m_valid && !m_is_final))
        else $error("round result flagged as final");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import dsfr_pkg::*;

    localparam int CHECK_BITS  = 16;
    localparam int DATA_BITS   = CHECK_BITS + 1;
    localparam int NUM_RANDOM  = 1736;
    localparam int NUM_PHASES  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 250000;
    localparam int MAX_PRINTS  = 40;

    // directed table row kinds
    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_MODE = 1'b1;

    // reset_mode register values
    localparam logic MODE_NO_RESET = 1'b0;
    localparam logic MODE_RESET    = 1'b1;

    typedef struct packed {
        logic [CHECK_BITS-1:0] det;
        logic                  fin;
    } syndrome_t;

    typedef struct packed {
        logic                  kind;
        logic                  mode;
        logic                  op;
        logic [CHECK_BITS-1:0] chk;
        logic [CHECK_BITS:0]   dat;
        logic                  typed;
        logic [CHECK_BITS-1:0] tdet;
        logic                  tfin;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic                  cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_op;
    logic [CHECK_BITS-1:0] s_check_bits;
    logic [CHECK_BITS:0]   s_data_bits;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHECK_BITS-1:0] m_detector_bits;
    logic                  m_is_final;

    // predictor state
    logic                  mode_q;
    logic [CHECK_BITS-1:0] last_round_q;
    logic [CHECK_BITS-1:0] last_diff_q;

    syndrome_t expected_syndromes[$];
    syndrome_t oldest_syndrome;

    int   err_count    = 0;
    int   items_sent   = 0;
    int   results_seen = 0;
    int   shots_done   = 0;
    int   mode_writes  = 0;
    int   cycle_count  = 0;
    int   rounds_left  = 0;
    logic hold_off_req = 1'b0;

    // directed rows: shot boundaries, extremes, unused fields, mode change mid-shot
    row_t directed_rows [0:22] = '{
        '{ROW_ITEM, MODE_NO_RESET, OP_FINAL, 16'h0000, 17'h1FFFF, 1'b1, 16'h0000, 1'b1},
        '{ROW_ITEM, MODE_NO_RESET, OP_ROUND, 16'hFFFF, 17'h00000, 1'b1, 16'hFFFF, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_ROUND, 16'hFFFF, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_ROUND, 16'h0000, 17'h1FFFF, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_ROUND, 16'hA5A5, 17'h1FFFF, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_FINAL, 16'hFFFF, 17'h0AAAA, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_ROUND, 16'h0000, 17'h00000, 1'b1, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_FINAL, 16'h0000, 17'h10000, 1'b0, 16'h0000, 1'b0},
        '{ROW_MODE, MODE_RESET,    OP_ROUND, 16'h0000, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_RESET,    OP_ROUND, 16'h8001, 17'h1FFFF, 1'b1, 16'h8001, 1'b0},
        '{ROW_ITEM, MODE_RESET,    OP_ROUND, 16'h7FFE, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_RESET,    OP_FINAL, 16'h0000, 17'h00001, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_RESET,    OP_FINAL, 16'hFFFF, 17'h0AAAA, 1'b1, 16'hFFFF, 1'b1},
        '{ROW_ITEM, MODE_RESET,    OP_ROUND, 16'h1234, 17'h00000, 1'b1, 16'h1234, 1'b0},
        '{ROW_MODE, MODE_NO_RESET, OP_ROUND, 16'h0000, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_ROUND, 16'h4321, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_ROUND, 16'hFFFF, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_MODE, MODE_RESET,    OP_ROUND, 16'h0000, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_RESET,    OP_ROUND, 16'h0F0F, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_RESET,    OP_FINAL, 16'h0000, 17'h15555, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_RESET,    OP_FINAL, 16'h0000, 17'h10000, 1'b1, 16'h8000, 1'b1},
        '{ROW_MODE, MODE_NO_RESET, OP_ROUND, 16'h0000, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{ROW_ITEM, MODE_NO_RESET, OP_FINAL, 16'h0000, 17'h00001, 1'b1, 16'h0001, 1'b1}
    };

    detector_syndrome_from_rounds #(
        .CHECK_BITS(CHECK_BITS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_check_bits    (s_check_bits),
        .s_data_bits     (s_data_bits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_detector_bits (m_detector_bits),
        .m_is_final      (m_is_final)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // detector word for one item, advancing the round history
    function automatic syndrome_t form_syndrome(input logic op,
                                                input logic [CHECK_BITS-1:0] chk,
                                                input logic [CHECK_BITS:0] dat);
        syndrome_t             s;
        logic [CHECK_BITS-1:0] diff;
        logic [CHECK_BITS:0]   edges;
        if (op == OP_ROUND) begin
            diff         = chk ^ last_round_q;
            s.det        = (mode_q == MODE_RESET) ? diff : (diff ^ last_diff_q);
            s.fin        = 1'b0;
            last_round_q = chk;
            last_diff_q  = diff;
        end else begin
            edges        = dat ^ (dat >> 1);
            s.det        = edges[CHECK_BITS-1:0]
                         ^ ((mode_q == MODE_RESET) ? last_round_q : last_diff_q);
            s.fin        = 1'b1;
            last_round_q = '0;
            last_diff_q  = '0;
        end
        return s;
    endfunction

    // one random item, shaped as shots of rounds closed by a final readout
    function automatic row_t next_random_item();
        row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        if ($urandom_range(0, 19) == 0)
            r.op = ($urandom_range(0, 1) == 1) ? OP_FINAL : OP_ROUND;
        else
            r.op = (rounds_left == 0) ? OP_FINAL : OP_ROUND;
        // often sparse changes between rounds (one flipped bit), as real syndromes are
        case ($urandom_range(0, 7))
            0:       r.chk = '0;
            1:       r.chk = '1;
            2, 3, 4: r.chk = last_round_q ^ (16'h1 << $urandom_range(0, CHECK_BITS - 1));
            default: r.chk = CHECK_BITS'($urandom_range(0, 16'hFFFF));
        endcase
        case ($urandom_range(0, 5))
            0:       r.dat = '0;
            1:       r.dat = '1;
            default: r.dat = DATA_BITS'($urandom_range(0, 17'h1FFFF));
        endcase
        if (r.op == OP_FINAL) begin
            case ($urandom_range(0, 9))
                0:       rounds_left = 0;
                1:       rounds_left = $urandom_range(20, 60);
                default: rounds_left = $urandom_range(1, 8);
            endcase
        end else if (rounds_left > 0) begin
            rounds_left--;
        end
        return r;
    endfunction

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // offer one item and hold it until the transfer
    task automatic send_item(input row_t r);
        syndrome_t s;
        s_valid      <= 1'b1;
        s_op         <= r.op;
        s_check_bits <= r.chk;
        s_data_bits  <= r.dat;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        s = form_syndrome(r.op, r.chk, r.dat);
        if (r.typed) begin
            s.det = r.tdet;
            s.fin = r.tfin;
        end
        expected_syndromes = {expected_syndromes, s};
        items_sent++;
        if (r.op == OP_FINAL)
            shots_done++;
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // reset_mode is written only once every result is back
    task automatic write_mode(input logic m);
        s_valid <= 1'b0;
        while (expected_syndromes.size() != 0)
            @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mode_q    = m;
        mode_writes++;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_syndromes.size() == 0) begin
                report_error("unexpected result", 32'({m_is_final, m_detector_bits}), 0);
            end else begin
                oldest_syndrome = expected_syndromes.pop_front();
                if (m_detector_bits !== oldest_syndrome.det)
                    report_error("detector_bits", 32'(m_detector_bits),
                                 32'(oldest_syndrome.det));
                if (m_is_final !== oldest_syndrome.fin)
                    report_error("is_final", 32'(m_is_final), 32'(oldest_syndrome.fin));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_syndromes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: rotating stall pattern, plus one long hold-off on request
    initial begin
        logic [31:0] stall_pattern;
        int          rx_cycles;
        logic        hold_done;
        m_ready       = 1'b0;
        stall_pattern = '1;
        rx_cycles     = 0;
        hold_done     = 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                if (rx_cycles % 64 == 0) begin
                    case ($urandom_range(0, 3))
                        0:       stall_pattern = '1;
                        1:       stall_pattern = $urandom;
                        2:       stall_pattern = $urandom | $urandom;
                        default: stall_pattern = $urandom & $urandom;
                    endcase
                end
                m_ready       <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
                rx_cycles++;
                @(posedge aclk);
            end
        end
    end

    // stimulus
    initial begin
        row_t r;
        int   burst_left;
        logic gaps_on;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = MODE_NO_RESET;
        s_valid      = 1'b0;
        s_op         = OP_ROUND;
        s_check_bits = '0;
        s_data_bits  = '0;
        mode_q       = MODE_NO_RESET;
        last_round_q = '0;
        last_diff_q  = '0;
        burst_left   = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_MODE)
                write_mode(directed_rows[i].mode);
            else
                send_item(directed_rows[i]);
        end

        // random phases; shots run on across mode writes
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_mode((p % 2 == 1) ? MODE_RESET : MODE_NO_RESET);
            gaps_on = (p > 1) && ($urandom_range(0, 3) != 0);
            if (p == 1)
                hold_off_req <= 1'b1;
            for (int k = 0; k < NUM_RANDOM / NUM_PHASES; k++) begin
                r = next_random_item();
                send_item(r);
                if (gaps_on) begin
                    if (burst_left == 0) begin
                        idle_gap($urandom_range(1, 8));
                        burst_left = $urandom_range(1, 20);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end

        // drain
        s_valid <= 1'b0;
        while (expected_syndromes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d items in %0d shots, %0d results checked",
                 items_sent, shots_done, results_seen);
        $display("reset_mode written %0d times, both settings, %0d errors",
                 mode_writes, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/dsfr_pkg.sv
rtl/core/dsfr_in_stage.sv
rtl/core/dsfr_syndrome.sv
rtl/core/dsfr_out_stage.sv
rtl/core/detector_syndrome_from_rounds.sv
test/tb.sv
